/* src/ngll_pkg.sv */
`default_nettype none

package ngll_pkg;

	// default configuration
	localparam int FRAC_DIGITS_DEF = 5;
	localparam int INT_DIGITS_DEF  = 5;

	// field widths
	localparam int BYTE_W = 8;
	localparam int UDEG_W = 31;
	localparam int MM_W   = 7;
	localparam int POS_W  = 3;

	// sentence head "$GPGLL"
	localparam int HEAD_LEN = 6;

	// ascii codes
	localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
	localparam logic [BYTE_W-1:0] CH_G      = 8'h47;
	localparam logic [BYTE_W-1:0] CH_P      = 8'h50;
	localparam logic [BYTE_W-1:0] CH_L      = 8'h4C;
	localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
	localparam logic [BYTE_W-1:0] CH_W      = 8'h57;

	// minutes scaled by 10^5 divide by 6 to give microdegrees
	localparam int     MIN_SCALE_BASE = 5;
	localparam longint MIN_DIV_BASE   = 6;
	localparam longint UDEG_PER_DEG   = 1000000;

	// largest magnitude of a converted coordinate
	localparam int UDEG_LIMIT = 1000666666;

	// parser phases
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_PREFIX,
		PH_SKIP,
		PH_LAT_INT,
		PH_LAT_FRAC,
		PH_LAT_DIR,
		PH_LAT_COMMA,
		PH_LON_INT,
		PH_LON_FRAC,
		PH_LON_DIR
	} phase_t;

	// control bits of one conversion job
	typedef struct packed {
		logic lon;
		logic neg;
	} job_ctl_t;

	// power of ten for elaboration-time constants
	function automatic longint pow10(input int n);
		longint r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/ngll_parser.sv */
`default_nettype none

module ngll_parser #(
	parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF,
	parameter int INT_DIGITS  = ngll_pkg::INT_DIGITS_DEF,
	localparam int DEG_W  = $clog2(ngll_pkg::pow10(INT_DIGITS - 2)),
	localparam int FRAC_W = $clog2(ngll_pkg::pow10(FRAC_DIGITS)),
	localparam int CNT_W  = $clog2(FRAC_DIGITS + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [ngll_pkg::BYTE_W-1:0] in_byte,
	output logic                        job_valid,
	input  logic                        job_ready,
	output ngll_pkg::job_ctl_t          job_ctl,
	output logic [DEG_W-1:0]            job_deg,
	output logic [ngll_pkg::MM_W-1:0]   job_mm,
	output logic [FRAC_W-1:0]           job_frac,
	output logic [CNT_W-1:0]            job_fcnt
);

	localparam int ICNT_W = $clog2(INT_DIGITS + 1);

	ngll_pkg::phase_t             phase_q, phase_d;
	logic [ngll_pkg::POS_W-1:0]   pos_q, pos_d;
	logic [3:0]                   dig_q [INT_DIGITS];
	logic [3:0]                   dig_d [INT_DIGITS];
	logic [ICNT_W-1:0]            icnt_q, icnt_d;
	logic [FRAC_W-1:0]            frac_q, frac_d;
	logic [CNT_W-1:0]             fcnt_q, fcnt_d;

	logic                         accept;
	logic                         is_digit;
	logic                         is_eol;
	logic                         has_digits;
	logic                         in_frac;
	logic                         in_lat;
	logic                         clear_num;
	logic [3:0]                   digit;
	logic [ngll_pkg::BYTE_W-1:0]  head_char;
	logic [DEG_W-1:0]             deg_sum;

	assign in_ready   = job_ready;
	assign accept     = in_valid && in_ready;
	assign digit      = in_byte[3:0];
	assign is_digit   = (in_byte >= ngll_pkg::CH_ZERO) && (in_byte <= ngll_pkg::CH_NINE);
	assign is_eol     = (in_byte == ngll_pkg::CH_CR) || (in_byte == ngll_pkg::CH_LF);
	assign has_digits = (icnt_q != '0) || (fcnt_q != '0);
	assign in_frac    = (phase_q == ngll_pkg::PH_LAT_FRAC) || (phase_q == ngll_pkg::PH_LON_FRAC);
	assign in_lat     = (phase_q == ngll_pkg::PH_LAT_INT) || (phase_q == ngll_pkg::PH_LAT_FRAC);

	// expected character of the sentence head
	always_comb begin
		case (pos_q)
			3'd0:    head_char = ngll_pkg::CH_DOLLAR;
			3'd1:    head_char = ngll_pkg::CH_G;
			3'd2:    head_char = ngll_pkg::CH_P;
			3'd3:    head_char = ngll_pkg::CH_G;
			default: head_char = ngll_pkg::CH_L;
		endcase
	end

	// next parse state for the byte on the port
	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		dig_d     = dig_q;
		icnt_d    = icnt_q;
		frac_d    = frac_q;
		fcnt_d    = fcnt_q;
		clear_num = 1'b0;
		if (in_byte == ngll_pkg::CH_DOLLAR) begin
			phase_d = ngll_pkg::PH_PREFIX;
			pos_d   = ngll_pkg::POS_W'(1);
		end else if (phase_q != ngll_pkg::PH_IDLE) begin
			if (is_eol) begin
				phase_d = ngll_pkg::PH_IDLE;
			end else begin
				case (phase_q)
					ngll_pkg::PH_PREFIX: begin
						if (in_byte == head_char) begin
							pos_d = ngll_pkg::POS_W'(pos_q + 1'b1);
							if (pos_q == ngll_pkg::POS_W'(ngll_pkg::HEAD_LEN - 1)) begin
								phase_d = ngll_pkg::PH_SKIP;
							end
						end else begin
							phase_d = ngll_pkg::PH_IDLE;
						end
					end
					ngll_pkg::PH_SKIP: begin
						if (in_byte == ngll_pkg::CH_COMMA) begin
							clear_num = 1'b1;
							phase_d   = ngll_pkg::PH_LAT_INT;
						end
					end
					ngll_pkg::PH_LAT_INT, ngll_pkg::PH_LAT_FRAC,
					ngll_pkg::PH_LON_INT, ngll_pkg::PH_LON_FRAC: begin
						if (is_digit) begin
							if (!in_frac) begin
								if (icnt_q == ICNT_W'(INT_DIGITS)) begin
									phase_d = ngll_pkg::PH_IDLE;
								end else begin
									for (int i = INT_DIGITS - 1; i > 0; i--) begin
										dig_d[i] = dig_q[i-1];
									end
									dig_d[0] = digit;
									icnt_d   = ICNT_W'(icnt_q + 1'b1);
								end
							end else if (fcnt_q < CNT_W'(FRAC_DIGITS)) begin
								frac_d = FRAC_W'((FRAC_W + 4)'(frac_q) * (FRAC_W + 4)'(10)
									+ (FRAC_W + 4)'(digit));
								fcnt_d = CNT_W'(fcnt_q + 1'b1);
							end
						end else if (in_byte == ngll_pkg::CH_DOT && !in_frac) begin
							phase_d = in_lat ? ngll_pkg::PH_LAT_FRAC : ngll_pkg::PH_LON_FRAC;
						end else if (in_byte == ngll_pkg::CH_COMMA && has_digits) begin
							phase_d = in_lat ? ngll_pkg::PH_LAT_DIR : ngll_pkg::PH_LON_DIR;
						end else begin
							phase_d = ngll_pkg::PH_IDLE;
						end
					end
					ngll_pkg::PH_LAT_DIR: begin
						phase_d = ngll_pkg::PH_LAT_COMMA;
					end
					ngll_pkg::PH_LAT_COMMA: begin
						if (in_byte == ngll_pkg::CH_COMMA) begin
							clear_num = 1'b1;
							phase_d   = ngll_pkg::PH_LON_INT;
						end else begin
							phase_d = ngll_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_d = ngll_pkg::PH_IDLE;
					end
				endcase
			end
		end
		if (clear_num) begin
			for (int i = 0; i < INT_DIGITS; i++) begin
				dig_d[i] = 4'd0;
			end
			icnt_d = '0;
			frac_d = '0;
			fcnt_d = '0;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ngll_pkg::PH_IDLE;
			pos_q   <= '0;
			icnt_q  <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			for (int i = 0; i < INT_DIGITS; i++) begin
				dig_q[i] <= 4'd0;
			end
		end else if (accept) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			icnt_q  <= icnt_d;
			frac_q  <= frac_d;
			fcnt_q  <= fcnt_d;
			dig_q   <= dig_d;
		end
	end

	// whole degrees from the upper integer digits
	always_comb begin
		deg_sum = '0;
		for (int i = 2; i < INT_DIGITS; i++) begin
			deg_sum = DEG_W'(deg_sum + DEG_W'(dig_q[i]) * DEG_W'(ngll_pkg::pow10(i - 2)));
		end
	end

	// a direction byte hands the held number to the converter
	assign job_valid = in_valid
		&& ((phase_q == ngll_pkg::PH_LAT_DIR) || (phase_q == ngll_pkg::PH_LON_DIR))
		&& (in_byte != ngll_pkg::CH_DOLLAR) && !is_eol;
	assign job_ctl.lon = (phase_q == ngll_pkg::PH_LON_DIR);
	assign job_ctl.neg = (in_byte == ngll_pkg::CH_S) || (in_byte == ngll_pkg::CH_W);
	assign job_deg     = deg_sum;
	assign job_mm      = ngll_pkg::MM_W'(ngll_pkg::MM_W'(dig_q[1]) * ngll_pkg::MM_W'(10)
		+ ngll_pkg::MM_W'(dig_q[0]));
	assign job_frac    = frac_q;
	assign job_fcnt    = fcnt_q;

endmodule

`default_nettype wire

/* src/ngll_convert.sv */
`default_nettype none

module ngll_convert #(
	parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF,
	parameter int INT_DIGITS  = ngll_pkg::INT_DIGITS_DEF,
	localparam int DEG_W  = $clog2(ngll_pkg::pow10(INT_DIGITS - 2)),
	localparam int FRAC_W = $clog2(ngll_pkg::pow10(FRAC_DIGITS)),
	localparam int CNT_W  = $clog2(FRAC_DIGITS + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               job_valid,
	output logic                               job_ready,
	input  ngll_pkg::job_ctl_t                 job_ctl,
	input  logic [DEG_W-1:0]                   job_deg,
	input  logic [ngll_pkg::MM_W-1:0]          job_mm,
	input  logic [FRAC_W-1:0]                  job_frac,
	input  logic [CNT_W-1:0]                   job_fcnt,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ngll_pkg::UDEG_W-1:0] latitude_udeg,
	output logic signed [ngll_pkg::UDEG_W-1:0] longitude_udeg
);

	// minutes are brought to a fixed scale of 10^SCALE_DIGITS
	localparam int SCALE_DIGITS = (FRAC_DIGITS > ngll_pkg::MIN_SCALE_BASE)
		? FRAC_DIGITS : ngll_pkg::MIN_SCALE_BASE;
	localparam longint X_LIMIT = ngll_pkg::pow10(SCALE_DIGITS + 2);
	localparam int     X_W     = $clog2(X_LIMIT);
	localparam longint DIVISOR = ngll_pkg::MIN_DIV_BASE
		* ngll_pkg::pow10(SCALE_DIGITS - ngll_pkg::MIN_SCALE_BASE);
	// reciprocal exact for every dividend below 2^X_W
	localparam int     SHIFT   = X_W + $clog2(DIVISOR);
	localparam longint RECIP   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int     R_W     = $clog2(RECIP + 1);
	localparam int     PROD_W  = X_W + R_W;
	localparam longint Q_MAX   = (X_LIMIT - 1) / DIVISOR;
	localparam int     Q_W     = $clog2(Q_MAX + 1);
	localparam longint MAG_MAX = (ngll_pkg::pow10(INT_DIGITS - 2) - 1) * ngll_pkg::UDEG_PER_DEG
		+ Q_MAX;
	localparam int     MAG_W   = $clog2(MAG_MAX + 1);

	// handshake between stages
	logic out_free, adv3, en1, en2, en3;

	logic                        v_s1, v_s2, v_s3;
	ngll_pkg::job_ctl_t          ctl_s1, ctl_s2, ctl_s3;
	logic [DEG_W-1:0]            deg_s1;
	logic [ngll_pkg::MM_W-1:0]   mm_s1;
	logic [FRAC_W-1:0]           frac_s1;
	logic [CNT_W-1:0]            fcnt_s1;
	logic [X_W-1:0]              x_s2;
	logic [MAG_W-1:0]            degu_s2, degu_s3;
	logic [Q_W-1:0]              q_s3;

	logic [X_W-1:0]              scale_sel;
	logic [X_W-1:0]              x_c;
	logic [MAG_W-1:0]            degu_c;
	logic [PROD_W-1:0]           prod_c;
	logic [MAG_W-1:0]            mag_c;
	logic [ngll_pkg::UDEG_W-1:0] udeg_c;

	logic                        out_valid_q;
	logic [ngll_pkg::UDEG_W-1:0] held_q, lat_q, lon_q;

	assign out_free  = !out_valid_q || out_ready;
	assign adv3      = !ctl_s3.lon || out_free;
	assign en3       = !v_s3 || adv3;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign job_ready = en1;

	// stage 1: minutes on the fixed scale, degrees in microdegrees
	always_comb begin
		scale_sel = '0;
		for (int k = 0; k <= FRAC_DIGITS; k++) begin
			if (fcnt_s1 == CNT_W'(k)) begin
				scale_sel = X_W'(ngll_pkg::pow10(SCALE_DIGITS - k));
			end
		end
	end
	assign x_c    = X_W'(X_W'(mm_s1) * X_W'(ngll_pkg::pow10(SCALE_DIGITS))
		+ X_W'(frac_s1) * scale_sel);
	assign degu_c = MAG_W'(MAG_W'(deg_s1) * MAG_W'(ngll_pkg::UDEG_PER_DEG));

	// stage 2: divide by the constant through its reciprocal
	assign prod_c = PROD_W'(x_s2) * PROD_W'(RECIP);

	// stage 3: sum and sign
	assign mag_c  = MAG_W'(degu_s3 + MAG_W'(q_s3));
	assign udeg_c = ctl_s3.neg ? ngll_pkg::UDEG_W'(-ngll_pkg::UDEG_W'(mag_c))
		: ngll_pkg::UDEG_W'(mag_c);

	// stage valid bits and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			held_q      <= '0;
		end else begin
			if (en1) begin
				v_s1 <= job_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (out_free) begin
				out_valid_q <= v_s3 && ctl_s3.lon;
			end
			// latitude waits here for its longitude
			if (v_s3 && !ctl_s3.lon) begin
				held_q <= udeg_c;
			end
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en1) begin
			ctl_s1  <= job_ctl;
			deg_s1  <= job_deg;
			mm_s1   <= job_mm;
			frac_s1 <= job_frac;
			fcnt_s1 <= job_fcnt;
		end
		if (en2) begin
			ctl_s2  <= ctl_s1;
			x_s2    <= x_c;
			degu_s2 <= degu_c;
		end
		if (en3) begin
			ctl_s3  <= ctl_s2;
			q_s3    <= prod_c[SHIFT +: Q_W];
			degu_s3 <= degu_s2;
		end
		if (out_free && v_s3 && ctl_s3.lon) begin
			lat_q <= held_q;
			lon_q <= udeg_c;
		end
	end

	assign out_valid      = out_valid_q;
	assign latitude_udeg  = lat_q;
	assign longitude_udeg = lon_q;

endmodule

`default_nettype wire

/* src/nmea_gll_position_parser_top.sv */
// channel   signals                                   transfer when
// --------  ----------------------------------------  ------------------------
// input     in_valid, in_ready, in_byte                in_valid && in_ready
// output    out_valid, out_ready, latitude_udeg,       out_valid && out_ready
//           longitude_udeg
//
// one byte is taken every cycle while in_ready is high; the parser state updates
// at the byte transfer; out_valid rises once the longitude direction byte has passed
// the job register, scale, reciprocal multiply, sum and sign into the output register
// arst_n clears the parse state and all stage valid bits; no clearing pass
// an output stall fills the conversion stages; in_ready drops only once every
// stage holds a job and the last one, a longitude, waits behind a held output
`default_nettype none

module nmea_gll_position_parser_top #(
	parameter int FRAC_DIGITS = ngll_pkg::FRAC_DIGITS_DEF,
	parameter int INT_DIGITS  = ngll_pkg::INT_DIGITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ngll_pkg::BYTE_W-1:0]        in_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ngll_pkg::UDEG_W-1:0] latitude_udeg,
	output logic signed [ngll_pkg::UDEG_W-1:0] longitude_udeg
);

	localparam int DEG_W  = $clog2(ngll_pkg::pow10(INT_DIGITS - 2));
	localparam int FRAC_W = $clog2(ngll_pkg::pow10(FRAC_DIGITS));
	localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);

	logic                      job_valid;
	logic                      job_ready;
	ngll_pkg::job_ctl_t        job_ctl;
	logic [DEG_W-1:0]          job_deg;
	logic [ngll_pkg::MM_W-1:0] job_mm;
	logic [FRAC_W-1:0]         job_frac;
	logic [CNT_W-1:0]          job_fcnt;

	// sentence parsing
	ngll_parser #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.INT_DIGITS (INT_DIGITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_ctl  (job_ctl),
		.job_deg  (job_deg),
		.job_mm   (job_mm),
		.job_frac (job_frac),
		.job_fcnt (job_fcnt)
	);

	// conversion to microdegrees
	ngll_convert #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.INT_DIGITS (INT_DIGITS)
	) u_convert (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (job_valid),
		.job_ready     (job_ready),
		.job_ctl       (job_ctl),
		.job_deg       (job_deg),
		.job_mm        (job_mm),
		.job_frac      (job_frac),
		.job_fcnt      (job_fcnt),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.latitude_udeg (latitude_udeg),
		.longitude_udeg(longitude_udeg)
	);

`ifndef SYNTHESIS
	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (latitude_udeg <= ngll_pkg::UDEG_LIMIT)
			&& (latitude_udeg >= -ngll_pkg::UDEG_LIMIT))
		else $error("latitude out of range");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (longitude_udeg <= ngll_pkg::UDEG_LIMIT)
			&& (longitude_udeg >= -ngll_pkg::UDEG_LIMIT))
		else $error("longitude out of range");

	a_job_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |-> (in_valid && in_ready))
		else $error("conversion job without a byte transfer");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while the output is not stalled");
`endif

endmodule

`default_nettype wire
